[rtl/rkvp_pkg.sv]
// ----------------------------------------------------------------------------
// rkvp_pkg: shared types and constants of the RESP key/value request parser
// Parse phases, event kinds, command and error codes, and the command words.
// ----------------------------------------------------------------------------
package rkvp_pkg;

    // Default width of argument counters
    localparam int RKVP_COUNT_BITS = 31;

    // Parse phases
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_CNT_FIRST  = 4'd1,
        PH_CNT_DIG    = 4'd2,
        PH_CNT_LF     = 4'd3,
        PH_BULK_START = 4'd4,
        PH_LEN_FIRST  = 4'd5,
        PH_LEN_DIG    = 4'd6,
        PH_LEN_LF     = 4'd7,
        PH_DATA       = 4'd8,
        PH_DATA_CR    = 4'd9,
        PH_DATA_LF    = 4'd10
    } t_phase;

    // Event kinds
    localparam logic [1:0] EV_KEY   = 2'd0;
    localparam logic [1:0] EV_VALUE = 2'd1;
    localparam logic [1:0] EV_DONE  = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // Command codes
    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_PUT     = 2'd1;
    localparam logic [1:0] CMD_REMOVE  = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NO_STAR      = 3'd0;
    localparam logic [2:0] ERR_BAD_COUNT    = 3'd1;
    localparam logic [2:0] ERR_NEG_COUNT    = 3'd2;
    localparam logic [2:0] ERR_BAD_BULK     = 3'd3;
    localparam logic [2:0] ERR_ARG_MISMATCH = 3'd4;
    localparam logic [2:0] ERR_LIMIT        = 3'd5;

    // Configuration register indexes
    localparam logic REG_MAX_ARG_COUNT   = 1'b0;
    localparam logic REG_MAX_BULK_LENGTH = 1'b1;

    // Protocol characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Command words
    localparam logic [7:0] WORD_GET [3] = '{8'h47, 8'h45, 8'h54};
    localparam logic [7:0] WORD_PUT [3] = '{8'h50, 8'h55, 8'h54};
    localparam logic [7:0] WORD_REM [6] = '{8'h52, 8'h45, 8'h4D, 8'h4F, 8'h56, 8'h45};

    // Per-word control between the top level and the parser
    typedef struct packed {
        logic load;   // output register may take a new word
        logic step;   // a buffered input word is consumed this cycle
    } t_step_ctl;

endpackage

[rtl/rkvp_dec_acc.sv]
// ----------------------------------------------------------------------------
// rkvp_dec_acc: saturating decimal accumulator step
// Computes acc * 10 + digit, clamped to the 32-bit maximum.
// ----------------------------------------------------------------------------
module rkvp_dec_acc (
    input  logic [31:0] i_acc,
    input  logic [3:0]  i_digit,
    output logic [31:0] o_acc
);

    logic [35:0] w_sum;

    // Multiply by ten as shift-and-add, then add the digit
    assign w_sum = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + {32'd0, i_digit};

    // Clamp on overflow
    assign o_acc = (|w_sum[35:32]) ? 32'hFFFF_FFFF : w_sum[31:0];

endmodule

[rtl/rkvp_parser.sv]
// ----------------------------------------------------------------------------
// rkvp_parser: request state machine and result register
// Consumes one buffered byte per step, updates the parse state and loads
// at most one event word into the output register.
// ----------------------------------------------------------------------------
module rkvp_parser #(
    parameter int COUNT_BITS = rkvp_pkg::RKVP_COUNT_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rkvp_pkg::t_step_ctl i_ctl,
    input  logic [7:0]         i_byte,
    input  logic [30:0]        i_max_arg_count,
    input  logic [30:0]        i_max_bulk_length,
    output logic               o_valid,
    output logic [1:0]         o_event_kind,
    output logic [7:0]         o_data_byte,
    output logic [1:0]         o_command,
    output logic [2:0]         o_error_code
);

    import rkvp_pkg::*;

    // Parse state
    t_phase                  r_phase, n_phase;
    logic [31:0]             r_acc, n_acc;
    logic                    r_neg, n_neg;
    logic [COUNT_BITS-1:0]   r_args_rem, n_args_rem;
    logic [1:0]              r_arg_pos, n_arg_pos;
    logic [30:0]             r_bytes_rem, n_bytes_rem;
    logic [2:0]              r_cand, n_cand;
    logic [2:0]              r_off, n_off;
    logic [1:0]              r_cmd, n_cmd;
    logic [COUNT_BITS-1:0]   r_total, n_total;

    // Result register
    logic                    r_out_valid;
    logic [1:0]              r_kind;
    logic [7:0]              r_data;
    logic [1:0]              r_out_cmd;
    logic [2:0]              r_err;

    // Combinational results of one step
    logic                    n_emit;
    logic [1:0]              n_kind;
    logic [7:0]              n_data;
    logic [1:0]              n_out_cmd;
    logic [2:0]              n_err;

    logic                    w_digit;
    logic [31:0]             w_acc_dig;
    logic [2:0]              w_cand_m;
    logic [2:0]              w_off_m;
    logic [1:0]              w_ad_cmd;
    logic [1:0]              w_ad_pos;
    logic [COUNT_BITS-1:0]   w_ad_args;
    logic [COUNT_BITS-1:0]   w_need;
    logic                    w_cnt_over;
    logic [30:0]             w_bytes_dec;

    assign w_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);

    rkvp_dec_acc u_dec_acc (
        .i_acc   (r_acc),
        .i_digit (i_byte[3:0]),
        .o_acc   (w_acc_dig)
    );

    // Narrow the command candidates with the current byte
    always_comb begin
        w_cand_m    = r_cand;
        if (!((r_off < 3'd3) && (i_byte == WORD_GET[r_off[1:0]]))) begin
            w_cand_m[0] = 1'b0;
        end
        if (!((r_off < 3'd3) && (i_byte == WORD_PUT[r_off[1:0]]))) begin
            w_cand_m[1] = 1'b0;
        end
        if (!((r_off < 3'd6) && (i_byte == WORD_REM[r_off]))) begin
            w_cand_m[2] = 1'b0;
        end
        w_off_m = (r_off < 3'd7) ? r_off + 3'd1 : r_off;
    end

    // Settle the command and counters at the end of an argument
    always_comb begin
        if (r_arg_pos != 2'd0) begin
            w_ad_cmd = r_cmd;
        end else if (r_cand[0] && (r_off == 3'd3)) begin
            w_ad_cmd = CMD_GET;
        end else if (r_cand[1] && (r_off == 3'd3)) begin
            w_ad_cmd = CMD_PUT;
        end else if (r_cand[2] && (r_off == 3'd6)) begin
            w_ad_cmd = CMD_REMOVE;
        end else begin
            w_ad_cmd = CMD_UNKNOWN;
        end
        w_ad_pos  = (r_arg_pos < 2'd3) ? r_arg_pos + 2'd1 : r_arg_pos;
        w_ad_args = (r_args_rem != '0) ? r_args_rem - COUNT_BITS'(1) : r_args_rem;
        w_need    = (w_ad_cmd == CMD_PUT) ? COUNT_BITS'(3) : COUNT_BITS'(2);
    end

    // Count above the configured limit or above the counter width
    assign w_cnt_over  = (r_acc > {1'b0, i_max_arg_count}) || (|r_acc[31:COUNT_BITS]);
    assign w_bytes_dec = (r_bytes_rem != '0) ? r_bytes_rem - 31'd1 : r_bytes_rem;

    // Next state and event
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_args_rem  = r_args_rem;
        n_arg_pos   = r_arg_pos;
        n_bytes_rem = r_bytes_rem;
        n_cand      = r_cand;
        n_off       = r_off;
        n_cmd       = r_cmd;
        n_total     = r_total;
        n_emit      = 1'b0;
        n_kind      = EV_KEY;
        n_data      = 8'd0;
        n_out_cmd   = CMD_GET;
        n_err       = ERR_NO_STAR;

        case (r_phase)
            PH_CNT_FIRST, PH_LEN_FIRST: begin
                if (i_byte == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = (r_phase == PH_CNT_FIRST) ? PH_CNT_DIG : PH_LEN_DIG;
                end else if (w_digit) begin
                    n_acc   = w_acc_dig;
                    n_phase = (r_phase == PH_CNT_FIRST) ? PH_CNT_DIG : PH_LEN_DIG;
                end else begin
                    n_phase = PH_IDLE;
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_emit  = 1'b1;
                    n_kind  = EV_ERROR;
                    n_err   = (r_phase == PH_CNT_FIRST) ? ERR_BAD_COUNT : ERR_BAD_BULK;
                end
            end
            PH_CNT_DIG, PH_LEN_DIG: begin
                if (w_digit) begin
                    n_acc = w_acc_dig;
                end else if (i_byte == CH_CR) begin
                    n_phase = (r_phase == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
                end else begin
                    n_phase = PH_IDLE;
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_emit  = 1'b1;
                    n_kind  = EV_ERROR;
                    n_err   = (r_phase == PH_CNT_DIG) ? ERR_BAD_COUNT : ERR_BAD_BULK;
                end
            end
            PH_CNT_LF: begin
                if ((i_byte != CH_LF) || (r_neg && (r_acc != '0)) || w_cnt_over
                    || (r_acc == '0)) begin
                    n_phase = PH_IDLE;
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_emit  = 1'b1;
                    n_kind  = EV_ERROR;
                    if (i_byte != CH_LF) begin
                        n_err = ERR_BAD_COUNT;
                    end else if (r_neg && (r_acc != '0)) begin
                        n_err = ERR_NEG_COUNT;
                    end else if (w_cnt_over) begin
                        n_err = ERR_LIMIT;
                    end else begin
                        n_err = ERR_ARG_MISMATCH;
                    end
                end else begin
                    n_total    = r_acc[COUNT_BITS-1:0];
                    n_args_rem = r_acc[COUNT_BITS-1:0];
                    n_acc      = '0;
                    n_neg      = 1'b0;
                    n_phase    = PH_BULK_START;
                end
            end
            PH_BULK_START: begin
                n_acc = '0;
                n_neg = 1'b0;
                if (i_byte != CH_DOLLAR) begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                    n_kind  = EV_ERROR;
                    n_err   = ERR_BAD_BULK;
                end else begin
                    n_phase = PH_LEN_FIRST;
                end
            end
            PH_LEN_LF, PH_DATA_LF: begin
                n_acc = '0;
                n_neg = 1'b0;
                if (i_byte != CH_LF) begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                    n_kind  = EV_ERROR;
                    n_err   = ERR_BAD_BULK;
                end else if ((r_phase == PH_LEN_LF) && !(r_neg && (r_acc != '0))) begin
                    // Plain length: check the limit and enter the data bytes
                    if (r_acc > {1'b0, i_max_bulk_length}) begin
                        n_phase = PH_IDLE;
                        n_emit  = 1'b1;
                        n_kind  = EV_ERROR;
                        n_err   = ERR_LIMIT;
                    end else begin
                        n_bytes_rem = r_acc[30:0];
                        n_phase     = (r_acc == '0) ? PH_DATA_CR : PH_DATA;
                    end
                end else begin
                    // Argument ends: data trailer, or a negative length
                    n_cmd      = w_ad_cmd;
                    n_arg_pos  = w_ad_pos;
                    n_args_rem = w_ad_args;
                    if (w_ad_args != '0) begin
                        n_phase = PH_BULK_START;
                    end else begin
                        n_phase = PH_IDLE;
                        n_emit  = 1'b1;
                        if ((w_ad_cmd != CMD_UNKNOWN) && (r_total != w_need)) begin
                            n_kind = EV_ERROR;
                            n_err  = ERR_ARG_MISMATCH;
                        end else begin
                            n_kind    = EV_DONE;
                            n_out_cmd = w_ad_cmd;
                        end
                    end
                end
            end
            PH_DATA: begin
                n_bytes_rem = w_bytes_dec;
                if (w_bytes_dec == '0) begin
                    n_phase = PH_DATA_CR;
                end
                if (r_arg_pos == 2'd0) begin
                    n_cand = w_cand_m;
                    n_off  = w_off_m;
                end else if ((r_cmd != CMD_UNKNOWN) && (r_arg_pos != 2'd3)) begin
                    n_emit = 1'b1;
                    n_kind = (r_arg_pos == 2'd1) ? EV_KEY : EV_VALUE;
                    n_data = i_byte;
                end
            end
            PH_DATA_CR: begin
                if (i_byte != CH_CR) begin
                    n_phase = PH_IDLE;
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_emit  = 1'b1;
                    n_kind  = EV_ERROR;
                    n_err   = ERR_BAD_BULK;
                end else begin
                    n_phase = PH_DATA_LF;
                end
            end
            default: begin
                n_acc = '0;
                n_neg = 1'b0;
                if (i_byte != CH_STAR) begin
                    n_phase = PH_IDLE;
                    n_emit  = 1'b1;
                    n_kind  = EV_ERROR;
                    n_err   = ERR_NO_STAR;
                end else begin
                    n_args_rem  = '0;
                    n_arg_pos   = 2'd0;
                    n_bytes_rem = '0;
                    n_cand      = 3'b111;
                    n_off       = 3'd0;
                    n_cmd       = CMD_UNKNOWN;
                    n_total     = '0;
                    n_phase     = PH_CNT_FIRST;
                end
            end
        endcase
    end

    // Advance the parse state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_args_rem  <= '0;
            r_arg_pos   <= 2'd0;
            r_bytes_rem <= '0;
            r_cand      <= 3'b111;
            r_off       <= 3'd0;
            r_cmd       <= CMD_UNKNOWN;
            r_total     <= '0;
        end else if (i_ctl.step) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_args_rem  <= n_args_rem;
            r_arg_pos   <= n_arg_pos;
            r_bytes_rem <= n_bytes_rem;
            r_cand      <= n_cand;
            r_off       <= n_off;
            r_cmd       <= n_cmd;
            r_total     <= n_total;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_out_valid <= i_ctl.step && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_ctl.step && n_emit) begin
            r_kind    <= n_kind;
            r_data    <= n_data;
            r_out_cmd <= n_out_cmd;
            r_err     <= n_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_data_byte  = r_data;
    assign o_command    = r_out_cmd;
    assign o_error_code = r_err;

endmodule

[rtl/resp_kv_request_parser.sv]
// ----------------------------------------------------------------------------
// resp_kv_request_parser: RESP array request parser, one byte per cycle when not stalled
// Each accepted byte is registered, then its event word is loaded into the result register.
// A full result register held by an output stall holds the parser and stalls the input.
// Reset: synchronous active low; parser idle, limits at 2^31-1, no output.
// ----------------------------------------------------------------------------
module resp_kv_request_parser #(
    parameter int COUNT_BITS = rkvp_pkg::RKVP_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // Event output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_command,
    output logic [2:0]  o_error_code,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    import rkvp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [30:0] r_max_arg_count;
    logic [30:0] r_max_bulk_length;
    logic        w_load;
    t_step_ctl   w_ctl;

    // Advance when the result register is free or being emptied
    assign w_load      = !(o_out_valid && i_out_stall);
    assign w_ctl       = '{load: w_load, step: w_load && r_in_valid};
    assign o_in_stall  = r_in_valid && !w_load;
    assign o_cfg_ready = 1'b1;

    // Input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_arg_count   <= 31'h7FFF_FFFF;
            r_max_bulk_length <= 31'h7FFF_FFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MAX_ARG_COUNT: begin
                    r_max_arg_count <= i_cfg_data;
                end
                REG_MAX_BULK_LENGTH: begin
                    r_max_bulk_length <= i_cfg_data;
                end
                default: begin
                    r_max_arg_count <= r_max_arg_count;
                end
            endcase
        end
    end

    rkvp_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .i_byte            (r_in_byte),
        .i_max_arg_count   (r_max_arg_count),
        .i_max_bulk_length (r_max_bulk_length),
        .o_valid           (o_out_valid),
        .o_event_kind      (o_event_kind),
        .o_data_byte       (o_data_byte),
        .o_command         (o_command),
        .o_error_code      (o_error_code)
    );

endmodule

[tb/resp_kv_request_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_kv_request_parser_tb: self-checking bench for the RESP request parser
// Drives directed and random request streams under varied backpressure and
// limit settings. An in-bench copy of the parsing rules predicts every event
// word, and each output word is checked in order against that prediction.
// ----------------------------------------------------------------------------
module resp_kv_request_parser_tb;

    import rkvp_pkg::*;

    // One predicted or observed event word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] command;
        logic [2:0] error_code;
    } t_event;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_event_kind;
    logic [7:0]  o_data_byte;
    logic [1:0]  o_command;
    logic [2:0]  o_error_code;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = REG_MAX_ARG_COUNT;
    logic [30:0] i_cfg_data  = '0;

    // Expected event words, oldest first
    t_event      pending_events[$];
    // Request bytes waiting to be sent
    logic [7:0]  tx_bytes[$];

    int fail_count    = 0;
    int bytes_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;

    // Parser state as predicted by the bench
    t_phase      ph          = PH_IDLE;
    logic [31:0] acc         = '0;
    logic        neg         = 1'b0;
    logic [30:0] args_left   = '0;
    logic [1:0]  arg_pos     = '0;
    logic [30:0] bytes_left  = '0;
    logic [2:0]  cand        = 3'b111;
    logic [2:0]  moff        = '0;
    logic [1:0]  cmd_p       = CMD_UNKNOWN;
    logic [30:0] total_args  = '0;
    logic [30:0] lim_args    = 31'h7FFF_FFFF;
    logic [30:0] lim_len     = 31'h7FFF_FFFF;

    resp_kv_request_parser u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_data_byte  (o_data_byte),
        .o_command    (o_command),
        .o_error_code (o_error_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Event prediction
    // ------------------------------------------------------------------
    function void expect_event(input logic [1:0] k, input logic [7:0] d,
                               input logic [1:0] c, input logic [2:0] e);
        t_event ev;
        ev.kind       = k;
        ev.data_byte  = d;
        ev.command    = c;
        ev.error_code = e;
        pending_events.insert(pending_events.size(), ev);
    endfunction

    // Drop back to idle and flag the fault
    function void parse_fault(input logic [2:0] e);
        ph  = PH_IDLE;
        acc = '0;
        neg = 1'b0;
        expect_event(EV_ERROR, '0, '0, e);
    endfunction

    // Decimal digit into the accumulator, saturating at 2^32-1
    function void accumulate_digit(input logic [7:0] b);
        logic [35:0] v;
        v   = {4'd0, acc} * 36'd10 + 36'(b - CH_ZERO);
        acc = (v > 36'hF_FFFF_FFFF >> 4) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Narrow the command candidates with one byte of the first argument
    function void match_command_byte(input logic [7:0] b);
        if (moff >= 3'd3 || b != WORD_GET[moff]) cand[0] = 1'b0;
        if (moff >= 3'd3 || b != WORD_PUT[moff]) cand[1] = 1'b0;
        if (moff >= 3'd6 || b != WORD_REM[moff]) cand[2] = 1'b0;
        if (moff < 3'd7) moff++;
    endfunction

    // Close one argument; on the last one settle the request
    function void finish_arg();
        logic [30:0] need;
        if (arg_pos == 2'd0) begin
            if (cand[0] && moff == 3'd3)      cmd_p = CMD_GET;
            else if (cand[1] && moff == 3'd3) cmd_p = CMD_PUT;
            else if (cand[2] && moff == 3'd6) cmd_p = CMD_REMOVE;
            else                              cmd_p = CMD_UNKNOWN;
        end
        if (arg_pos < 2'd3) arg_pos++;
        if (args_left > 0) args_left--;
        if (args_left != 0) begin
            ph = PH_BULK_START;
            return;
        end
        ph = PH_IDLE;
        if (cmd_p != CMD_UNKNOWN) begin
            need = (cmd_p == CMD_PUT) ? 31'd3 : 31'd2;
            if (total_args != need) begin
                expect_event(EV_ERROR, '0, '0, ERR_ARG_MISMATCH);
                return;
            end
        end
        expect_event(EV_DONE, '0, cmd_p, '0);
    endfunction

    // Advance the predicted parser by one accepted byte
    function void parse_step(input logic [7:0] b);
        logic digit;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        case (ph)
            PH_CNT_FIRST, PH_LEN_FIRST: begin
                if (b == CH_MINUS || digit) begin
                    if (digit) accumulate_digit(b);
                    else neg = 1'b1;
                    ph = (ph == PH_CNT_FIRST) ? PH_CNT_DIG : PH_LEN_DIG;
                end else begin
                    parse_fault((ph == PH_CNT_FIRST) ? ERR_BAD_COUNT : ERR_BAD_BULK);
                end
            end
            PH_CNT_DIG, PH_LEN_DIG: begin
                if (digit) accumulate_digit(b);
                else if (b == CH_CR) ph = (ph == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
                else parse_fault((ph == PH_CNT_DIG) ? ERR_BAD_COUNT : ERR_BAD_BULK);
            end
            PH_CNT_LF: begin
                if (b != CH_LF) parse_fault(ERR_BAD_COUNT);
                else if (neg && acc != 0) parse_fault(ERR_NEG_COUNT);
                else if (acc > {1'b0, lim_args}) parse_fault(ERR_LIMIT);
                else if (acc == 0) parse_fault(ERR_ARG_MISMATCH);
                else begin
                    total_args = acc[30:0];
                    args_left  = acc[30:0];
                    acc        = '0;
                    neg        = 1'b0;
                    ph         = PH_BULK_START;
                end
            end
            PH_BULK_START: begin
                if (b != CH_DOLLAR) parse_fault(ERR_BAD_BULK);
                else begin
                    acc = '0;
                    neg = 1'b0;
                    ph  = PH_LEN_FIRST;
                end
            end
            PH_LEN_LF: begin
                if (b != CH_LF) parse_fault(ERR_BAD_BULK);
                else if (neg && acc != 0) begin
                    // negative length: empty argument, no data and no CRLF
                    acc = '0;
                    neg = 1'b0;
                    finish_arg();
                end else if (acc > {1'b0, lim_len}) parse_fault(ERR_LIMIT);
                else begin
                    bytes_left = acc[30:0];
                    acc        = '0;
                    neg        = 1'b0;
                    ph         = (bytes_left == 0) ? PH_DATA_CR : PH_DATA;
                end
            end
            PH_DATA: begin
                if (bytes_left > 0) bytes_left--;
                if (bytes_left == 0) ph = PH_DATA_CR;
                if (arg_pos == 2'd0) match_command_byte(b);
                else if (cmd_p != CMD_UNKNOWN && arg_pos != 2'd3)
                    expect_event((arg_pos == 2'd1) ? EV_KEY : EV_VALUE, b, '0, '0);
            end
            PH_DATA_CR: begin
                if (b != CH_CR) parse_fault(ERR_BAD_BULK);
                else ph = PH_DATA_LF;
            end
            PH_DATA_LF: begin
                if (b != CH_LF) parse_fault(ERR_BAD_BULK);
                else finish_arg();
            end
            default: begin
                ph = PH_IDLE;
                if (b != CH_STAR) parse_fault(ERR_NO_STAR);
                else begin
                    acc        = '0;
                    neg        = 1'b0;
                    args_left  = '0;
                    arg_pos    = '0;
                    bytes_left = '0;
                    cand       = 3'b111;
                    moff       = '0;
                    cmd_p      = CMD_UNKNOWN;
                    total_args = '0;
                    ph         = PH_CNT_FIRST;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request building
    // ------------------------------------------------------------------
    function void put_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endfunction

    function void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function void put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    // Lead character, signed decimal number, CRLF
    function void put_header(input logic [7:0] lead, input longint n);
        put_byte(lead);
        put_text($sformatf("%0d", n));
        put_crlf();
    endfunction

    function void put_bulk(input string s);
        put_header(CH_DOLLAR, s.len());
        put_text(s);
        put_crlf();
    endfunction

    function void put_random_bulk(input int len, input int lo, input int hi);
        put_header(CH_DOLLAR, len);
        repeat (len) put_byte(8'($urandom_range(hi, lo)));
        put_crlf();
    endfunction

    // Empty arguments: negative length, lone minus, minus zero, zero length
    function void put_odd_bulk();
        case ($urandom_range(0, 3))
            0: put_header(CH_DOLLAR, -longint'($urandom_range(1, 20)));
            1: begin
                put_byte(CH_DOLLAR);
                put_byte(CH_MINUS);
                put_crlf();
                put_crlf();
            end
            2: begin
                put_text("$-0");
                put_crlf();
                put_crlf();
            end
            default: put_bulk("");
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Handshake tasks
    // ------------------------------------------------------------------
    // Offer one word and hold it until taken; idle cycle by cycle first
    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_step(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
        tx_bytes.delete();
    endtask

    // Stop offering, wait for every expected word, then let the pipe settle
    task automatic drain_events();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic idx, input logic [30:0] val);
        drain_events();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_MAX_ARG_COUNT) lim_args = val;
        else lim_len = val;
    endtask

    // One random request, mostly well formed, sometimes noisy or broken
    task automatic send_random_request();
        string near_miss[5] = '{"GE", "PUTS", "REMOV", "REMOVEX", "get"};
        int pick;
        int nargs;
        int r;
        pick = $urandom_range(0, 9);
        if ($urandom_range(99) < 8)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        if (pick == 2 || pick == 3) nargs = 3;
        else if (pick < 6) nargs = 2;
        else nargs = $urandom_range(1, 4);
        if ($urandom_range(99) < 15) nargs = $urandom_range(1, 5);
        put_byte(CH_STAR);
        if ($urandom_range(9) == 0) put_byte(CH_ZERO);
        put_text($sformatf("%0d", nargs));
        put_crlf();
        case (pick)
            0, 1:    put_bulk("GET");
            2, 3:    put_bulk("PUT");
            4, 5:    put_bulk("REMOVE");
            6:       put_random_bulk($urandom_range(1, 6), 8'h41, 8'h5A);
            7:       put_bulk(near_miss[$urandom_range(0, 4)]);
            8:       put_odd_bulk();
            default: put_random_bulk($urandom_range(0, 6), 0, 255);
        endcase
        for (int a = 1; a < nargs; a++) begin
            if ($urandom_range(99) < 12) put_odd_bulk();
            else put_random_bulk($urandom_range(0, 6), 0, 255);
        end
        // corrupt a byte, or cut the request short
        r = $urandom_range(99);
        if (r < 10) begin
            tx_bytes[$urandom_range(0, tx_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 15) begin
            r = $urandom_range(1, tx_bytes.size() - 1);
            while (tx_bytes.size() > r) void'(tx_bytes.pop_back());
        end
        send_frame();
    endtask

    task automatic run_request_mix(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_random_request();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_malformed_input();
        // garbage while idle, field extremes
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("x");
        // empty count
        put_byte(CH_STAR);
        put_byte(CH_CR);
        // lone minus and minus zero read as a zero count
        put_byte(CH_STAR);
        put_byte(CH_MINUS);
        put_crlf();
        put_text("*-0");
        put_crlf();
        put_header(CH_STAR, -5);
        put_header(CH_STAR, 0);
        // stray bytes inside and after the count
        put_text("*2x");
        put_text("*2");
        put_byte(CH_CR);
        put_text("x");
        // saturated count
        put_text("*99999999999");
        put_crlf();
        // missing dollar, empty length, missing CRLF after data
        put_header(CH_STAR, 1);
        put_text("x");
        put_header(CH_STAR, 1);
        put_byte(CH_DOLLAR);
        put_byte(CH_CR);
        put_header(CH_STAR, 1);
        put_text("$1");
        put_crlf();
        put_text("Ax");
        put_header(CH_STAR, 1);
        put_text("$99999999999");
        put_crlf();
        send_frame();
        drain_events();
    endtask

    task automatic test_command_requests();
        put_header(CH_STAR, 2);
        put_bulk("GET");
        put_bulk("k1");
        put_header(CH_STAR, 3);
        put_bulk("PUT");
        put_bulk("key");
        put_bulk("val");
        put_header(CH_STAR, 2);
        put_bulk("REMOVE");
        put_bulk("k");
        // unknown command stays silent until done
        put_header(CH_STAR, 3);
        put_bulk("PING");
        put_bulk("ab");
        put_bulk("cd");
        // negative length gives an empty command word
        put_header(CH_STAR, 1);
        put_header(CH_DOLLAR, -1);
        put_header(CH_STAR, 2);
        put_bulk("GET");
        put_byte(CH_DOLLAR);
        put_byte(CH_MINUS);
        put_crlf();
        put_crlf();
        // wrong counts for a known command
        put_header(CH_STAR, 2);
        put_bulk("PUT");
        put_bulk("k");
        put_header(CH_STAR, 4);
        put_bulk("PUT");
        put_bulk("k");
        put_bulk("v");
        put_bulk("x");
        // largest count allowed by the reset limit is accepted
        put_header(CH_STAR, 2147483647);
        put_text("x");
        send_frame();
        drain_events();
    endtask

    task automatic test_limit_registers();
        write_limit(REG_MAX_ARG_COUNT, '0);
        write_limit(REG_MAX_BULK_LENGTH, '0);
        put_header(CH_STAR, 1);
        put_header(CH_STAR, 0);
        send_frame();
        write_limit(REG_MAX_ARG_COUNT, 31'd2);
        put_header(CH_STAR, 3);
        put_header(CH_STAR, 2);
        put_bulk("GET");
        put_header(CH_STAR, 1);
        put_bulk("");
        send_frame();
        write_limit(REG_MAX_BULK_LENGTH, 31'd3);
        put_header(CH_STAR, 2);
        put_bulk("GET");
        put_bulk("abc");
        put_header(CH_STAR, 2);
        put_bulk("PUTS");
        send_frame();
        write_limit(REG_MAX_ARG_COUNT, 31'h7FFF_FFFF);
        write_limit(REG_MAX_BULK_LENGTH, 31'h7FFF_FFFF);
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_request_mix(110);
        write_limit(REG_MAX_ARG_COUNT, 31'd3);
        write_limit(REG_MAX_BULK_LENGTH, 31'd5);
        send_idle_pct = 53;
        run_request_mix(110);
        write_limit(REG_MAX_ARG_COUNT, 31'($urandom));
        write_limit(REG_MAX_BULK_LENGTH, 31'($urandom));
        send_idle_pct = 0;
        stall_pct     = 53;
        run_request_mix(110);
        write_limit(REG_MAX_ARG_COUNT, 31'h7FFF_FFFF);
        write_limit(REG_MAX_BULK_LENGTH, 31'h7FFF_FFFF);
        send_idle_pct = 13;
        stall_pct     = 13;
        run_request_mix(110);
        drain_events();
    endtask

    // Hold the output off long enough to back the block up to its input
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 300;
        repeat (3) begin
            put_header(CH_STAR, 3);
            put_bulk("PUT");
            put_random_bulk(8, 0, 255);
            put_random_bulk(16, 0, 255);
        end
        send_frame();
        // pause until every word has come out
        drain_events();
        send_idle_pct = 13;
        stall_pct     = 13;
        run_request_mix(50);
        drain_events();
    endtask

    // ------------------------------------------------------------------
    // Output side: check each taken word, then choose the next stall
    // ------------------------------------------------------------------
    function void check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : out_side
        t_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual kind %0h data %0h",
                         $time, o_event_kind, o_data_byte);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", 8'(want.kind), 8'(o_event_kind));
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("command", 8'(want.command), 8'(o_command));
                check_field("error_code", 8'(want.error_code), 8'(o_error_code));
            end
        end
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_malformed_input();
        test_command_requests();
        test_limit_registers();
        test_random_traffic();
        test_output_hold_off();
        drain_events();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/rkvp_pkg.sv
rtl/rkvp_dec_acc.sv
rtl/rkvp_parser.sv
rtl/resp_kv_request_parser.sv
tb/resp_kv_request_parser_tb.sv
